// File: hdl/autotile_quadrant_selector_top_macros.svh
// Assertion helpers used by the RTL top-level file.
`ifndef AUTOTILE_QUADRANT_SELECTOR_TOP_MACROS_SVH
`define AUTOTILE_QUADRANT_SELECTOR_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ATQS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ATQS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/atqs_pkg.sv
`timescale 1ns / 1ps

package atqs_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 9;
    localparam int STEP_W     = 4;

    localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = 1'd1;

    localparam logic [CFG_DATA_W-1:0] MAP_DIM_RESET = 9'd250;

    localparam logic [0:0] CMD_WRITE = 1'b0;
    localparam logic [0:0] CMD_QUERY = 1'b1;

    localparam logic [2:0] PART_WHOLE = 3'd0;

    // Up, left, down and right neighbors of the same-type mask.
    localparam logic [7:0] ORTHO_MASK = 8'b10101010;

    // Step 0 reads the cell itself, step k reads the neighbor of mask bit k-1.
    localparam logic [STEP_W-1:0] STEP_CENTER = 4'd0;
    localparam logic [STEP_W-1:0] STEP_LAST   = 4'd8;

    typedef struct packed {
        logic signed [1:0] dx;
        logic signed [1:0] dy;
    } offset_t;

    typedef struct packed {
        logic [5:0] sx;
        logic [6:0] sy;
    } source_t;

    function automatic offset_t step_offset(input logic [STEP_W-1:0] step);
        offset_t o;
        case (step)
            4'd1:    o = '{dx:  2'sd1, dy: -2'sd1};
            4'd2:    o = '{dx:  2'sd1, dy:  2'sd0};
            4'd3:    o = '{dx:  2'sd1, dy:  2'sd1};
            4'd4:    o = '{dx:  2'sd0, dy:  2'sd1};
            4'd5:    o = '{dx: -2'sd1, dy:  2'sd1};
            4'd6:    o = '{dx: -2'sd1, dy:  2'sd0};
            4'd7:    o = '{dx: -2'sd1, dy: -2'sd1};
            4'd8:    o = '{dx:  2'sd0, dy: -2'sd1};
            default: o = '{dx:  2'sd0, dy:  2'sd0};
        endcase
        return o;
    endfunction

    // Quadrant order: bottom-right, bottom-left, top-left, top-right.
    // Returns the horizontal, vertical and diagonal neighbor bits of that quadrant.
    function automatic logic [2:0] quad_hvd(input logic [1:0] q, input logic [7:0] mask);
        logic [2:0] r;
        case (q)
            2'd0:    r = {mask[1], mask[3], mask[2]};
            2'd1:    r = {mask[5], mask[3], mask[4]};
            2'd2:    r = {mask[5], mask[7], mask[6]};
            default: r = {mask[1], mask[7], mask[0]};
        endcase
        return r;
    endfunction

    function automatic source_t quad_source(input logic [1:0] q, input logic [2:0] hvd);
        logic [2:0] sel;
        source_t s;
        if (hvd[2] && hvd[1]) begin
            sel = hvd[0] ? 3'd4 : 3'd3;
        end else if (hvd[2]) begin
            sel = 3'd1;
        end else if (hvd[1]) begin
            sel = 3'd2;
        end else begin
            sel = 3'd0;
        end
        case ({q, sel})
            {2'd0, 3'd0}: s = '{sx: 6'd48, sy: 7'd80};
            {2'd0, 3'd1}: s = '{sx: 6'd16, sy: 7'd80};
            {2'd0, 3'd2}: s = '{sx: 6'd48, sy: 7'd48};
            {2'd0, 3'd3}: s = '{sx: 6'd48, sy: 7'd16};
            {2'd0, 3'd4}: s = '{sx: 6'd16, sy: 7'd48};
            {2'd1, 3'd0}: s = '{sx: 6'd0,  sy: 7'd80};
            {2'd1, 3'd1}: s = '{sx: 6'd32, sy: 7'd80};
            {2'd1, 3'd2}: s = '{sx: 6'd0,  sy: 7'd48};
            {2'd1, 3'd3}: s = '{sx: 6'd32, sy: 7'd16};
            {2'd1, 3'd4}: s = '{sx: 6'd32, sy: 7'd48};
            {2'd2, 3'd0}: s = '{sx: 6'd0,  sy: 7'd32};
            {2'd2, 3'd1}: s = '{sx: 6'd32, sy: 7'd32};
            {2'd2, 3'd2}: s = '{sx: 6'd0,  sy: 7'd64};
            {2'd2, 3'd3}: s = '{sx: 6'd32, sy: 7'd0};
            {2'd2, 3'd4}: s = '{sx: 6'd32, sy: 7'd64};
            {2'd3, 3'd0}: s = '{sx: 6'd48, sy: 7'd32};
            {2'd3, 3'd1}: s = '{sx: 6'd16, sy: 7'd32};
            {2'd3, 3'd2}: s = '{sx: 6'd48, sy: 7'd64};
            {2'd3, 3'd3}: s = '{sx: 6'd48, sy: 7'd0};
            {2'd3, 3'd4}: s = '{sx: 6'd16, sy: 7'd64};
            default:      s = '{sx: 6'd0,  sy: 7'd0};
        endcase
        return s;
    endfunction

endpackage

// File: hdl/autotile_quadrant_selector_top.sv
// Autotile quadrant selector. The tile-type map lives in one single-port-read,
// single-port-write memory of MAP_SIDE*MAP_SIDE 3-bit cells. After reset the block
// first clears the whole memory, one cell per cycle; s_tready stays low meanwhile,
// while configuration writes are taken at any time. A write item is a transfer
// followed by the memory write, if the cell is inside the map. A query inside the
// map fetches the cell and its eight neighbors through the one read port, then
// loads one whole-tile result or four quadrant results into the output register,
// each as the register frees. A query outside the map skips the reads. The memory
// read port takes one address per cycle.
`timescale 1ns / 1ps

`include "autotile_quadrant_selector_top_macros.svh"

module autotile_quadrant_selector_top
    import atqs_pkg::*;
#(
    parameter int MAP_SIDE = 256
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [23:0]           s_tdata,   // cell_x[7:0], cell_y[15:8], new_type[18:16]
    input  logic [0:0]            s_tuser,   // command[0]

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata,   // source_x[5:0], source_y[12:6]
    output logic [5:0]            m_tuser,   // tile_type[2:0], part[5:3]
    output logic                  m_tlast,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int DEPTH  = MAP_SIDE * MAP_SIDE;
    localparam int ADDR_W = $clog2(DEPTH);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_EXEC  = 3'd2;
    localparam logic [2:0] ST_READ  = 3'd3;
    localparam logic [2:0] ST_DRAIN = 3'd4;
    localparam logic [2:0] ST_EMIT  = 3'd5;

    logic [2:0]            state_reg, state_next;
    logic [ADDR_W-1:0]     clr_addr_reg;
    logic [CFG_DATA_W-1:0] map_width_reg, map_height_reg;

    logic [0:0]            cmd_reg;
    logic [7:0]            cx_reg, cy_reg;
    logic [2:0]            nt_reg;

    logic [STEP_W-1:0]     step_reg;
    logic                  cap_valid_reg;
    logic [STEP_W-1:0]     cap_step_reg;
    logic                  cap_inside_reg;
    logic [2:0]            t_reg;
    logic [7:0]            mask_reg;
    logic [1:0]            quad_reg;

    logic                  m_tvalid_reg;
    logic [2:0]            out_type_reg, out_part_reg;
    source_t               out_src_reg;
    logic                  out_last_reg;

    logic [2:0]            mem [DEPTH];
    logic [2:0]            mem_rdata;
    logic                  mem_we, mem_re;
    logic [ADDR_W-1:0]     mem_waddr;
    logic [2:0]            mem_wdata;

    offset_t               ofs;
    logic signed [9:0]     nx, ny;
    logic                  nb_inside;
    logic [ADDR_W-1:0]     nb_addr;

    logic                  in_xfer;
    logic                  out_load;
    logic                  whole;
    source_t               qsrc;

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_xfer   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Coordinates of the cell addressed by the current step.
    always_comb begin
        ofs = step_offset(step_reg);
        nx  = $signed({2'b00, cx_reg}) + $signed({{8{ofs.dx[1]}}, ofs.dx});
        ny  = $signed({2'b00, cy_reg}) + $signed({{8{ofs.dy[1]}}, ofs.dy});
        nb_inside = !nx[9] && !ny[9]
                 && (nx[8:0] < map_width_reg) && (ny[8:0] < map_height_reg)
                 && (int'(nx[8:0]) < MAP_SIDE) && (int'(ny[8:0]) < MAP_SIDE);
        nb_addr = '0;
        if (nb_inside) begin
            nb_addr = ADDR_W'(ny[8:0]) * ADDR_W'(MAP_SIDE) + ADDR_W'(nx[8:0]);
        end
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = clr_addr_reg;
        mem_wdata = '0;
        if (state_reg == ST_CLEAR) begin
            mem_we = 1'b1;
        end else if (state_reg == ST_EXEC && cmd_reg == CMD_WRITE && nb_inside) begin
            mem_we    = 1'b1;
            mem_waddr = nb_addr;
            mem_wdata = nt_reg;
        end
    end

    assign mem_re = (state_reg == ST_READ);

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            mem_rdata <= mem[nb_addr];
        end
    end

    assign out_load = (state_reg == ST_EMIT) && (!m_tvalid_reg || m_tready);
    assign whole    = (mask_reg & ORTHO_MASK) == 8'd0;
    assign qsrc     = quad_source(quad_reg, quad_hvd(quad_reg, mask_reg));

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_addr_reg == ADDR_W'(DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_xfer) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (cmd_reg == CMD_WRITE) begin
                    state_next = ST_IDLE;
                end else if (nb_inside) begin
                    state_next = ST_READ;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_READ: begin
                if (step_reg == STEP_LAST) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_load && (whole || quad_reg == 2'd3)) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clr_addr_reg   <= '0;
            map_width_reg  <= MAP_DIM_RESET;
            map_height_reg <= MAP_DIM_RESET;
            cap_valid_reg  <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_MAP_WIDTH:  map_width_reg  <= cfg_data;
                    REG_MAP_HEIGHT: map_height_reg <= cfg_data;
                    default: ;
                endcase
            end
            cap_valid_reg <= mem_re;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            cmd_reg  <= s_tuser;
            cx_reg   <= s_tdata[7:0];
            cy_reg   <= s_tdata[15:8];
            nt_reg   <= s_tdata[18:16];
            step_reg <= STEP_CENTER;
        end
        if (state_reg == ST_EXEC) begin
            // An outside query reports type zero with an empty mask.
            mask_reg <= '0;
            t_reg    <= '0;
            quad_reg <= '0;
        end
        if (mem_re) begin
            step_reg       <= step_reg + 1'b1;
            cap_step_reg   <= step_reg;
            cap_inside_reg <= nb_inside;
        end
        // The cell's own type arrives before any neighbor is compared against it.
        if (cap_valid_reg) begin
            if (cap_step_reg == STEP_CENTER) begin
                t_reg <= mem_rdata;
            end else begin
                mask_reg[3'(cap_step_reg - 1'b1)] <= cap_inside_reg && (mem_rdata == t_reg);
            end
        end
        if (out_load) begin
            out_type_reg <= t_reg;
            if (whole) begin
                out_part_reg <= PART_WHOLE;
                out_src_reg  <= '0;
                out_last_reg <= 1'b1;
            end else begin
                out_part_reg <= {1'b0, quad_reg} + 3'd1;
                out_src_reg  <= qsrc;
                out_last_reg <= (quad_reg == 2'd3);
                quad_reg     <= quad_reg + 1'b1;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, out_src_reg.sy, out_src_reg.sx};
    assign m_tuser  = {out_part_reg, out_type_reg};
    assign m_tlast  = out_last_reg;

    `ATQS_ASSERT_NOW(a_no_input_during_clear, aclk, aresetn, state_reg == ST_CLEAR, !s_tready, "input taken while the map is being cleared")
    `ATQS_ASSERT_NOW(a_no_write_during_read, aclk, aresetn, mem_re, !mem_we, "map written while a query reads it")
    `ATQS_ASSERT_NOW(a_whole_is_last, aclk, aresetn, m_tvalid && m_tuser[5:3] == PART_WHOLE, m_tlast, "whole tile not marked last")
    `ATQS_ASSERT_NEXT(a_read_feeds_capture, aclk, aresetn, mem_re, cap_valid_reg, "memory read not captured")

endmodule

// File: tb/autotile_quadrant_selector_top_tb.sv
`timescale 1ns / 1ps

module autotile_quadrant_selector_top_tb;
    import atqs_pkg::*;

    localparam int SIDE = 256;
    localparam int DRAIN_CYCLES = 24;

    localparam logic [2:0] PART_BOTTOM_RIGHT = 3'd1;
    localparam logic [2:0] PART_BOTTOM_LEFT  = 3'd2;
    localparam logic [2:0] PART_TOP_LEFT     = 3'd3;
    localparam logic [2:0] PART_TOP_RIGHT    = 3'd4;

    // Piece selection within one quadrant's row of the sheet table.
    localparam int SEL_NONE      = 0;
    localparam int SEL_HORIZ     = 1;
    localparam int SEL_VERT      = 2;
    localparam int SEL_BOTH      = 3;
    localparam int SEL_BOTH_DIAG = 4;

    typedef struct {
        logic [0:0] cmd;
        logic [7:0] x;
        logic [7:0] y;
        logic [2:0] new_type;
    } cell_op_t;

    typedef struct packed {
        logic [2:0] tile_type;
        logic [2:0] part;
        logic [5:0] src_x;
        logic [6:0] src_y;
        logic       last;
    } piece_t;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [23:0]           s_tdata   = '0;
    logic [0:0]            s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [15:0]           m_tdata;
    logic [5:0]            m_tuser;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    autotile_quadrant_selector_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow of the block's tile map and size registers.
    logic [2:0] tile_map [0:SIDE*SIDE-1];
    logic [8:0] map_w = MAP_DIM_RESET;
    logic [8:0] map_h = MAP_DIM_RESET;

    // Neighbor offsets in same-type mask bit order.
    int nb_dx [8] = '{1, 1, 1, 0, -1, -1, -1, 0};
    int nb_dy [8] = '{-1, 0, 1, 1, 1, 0, -1, -1};

    // Horizontal, vertical and diagonal mask bits of each quadrant, in output order.
    int quad_h [4] = '{1, 5, 5, 1};
    int quad_v [4] = '{3, 3, 7, 7};
    int quad_d [4] = '{2, 4, 6, 0};
    logic [2:0] quad_part [4] = '{PART_BOTTOM_RIGHT, PART_BOTTOM_LEFT,
                                  PART_TOP_LEFT, PART_TOP_RIGHT};

    // Sheet offsets, five selections per quadrant.
    int sheet_x [20] = '{48, 16, 48, 48, 16,   0, 32,  0, 32, 32,
                          0, 32,  0, 32, 32,  48, 16, 48, 48, 16};
    int sheet_y [20] = '{80, 80, 48, 16, 48,  80, 80, 48, 16, 48,
                         32, 32, 64,  0, 64,  32, 32, 64,  0, 64};

    cell_op_t ops_waiting [$];
    piece_t   pieces_due [$];
    cell_op_t bus_op;
    piece_t   got;
    piece_t   want;

    int  ops_launched = 0;
    int  ops_accepted = 0;
    int  idle_left    = 0;
    int  stall_left   = 0;
    int  mismatches   = 0;
    bit  no_gaps      = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #10ms;
        $display("** autotile_quadrant_selector_top: FAILED **");
        $finish;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int eff_dim(input logic [8:0] v);
        return (v > SIDE) ? SIDE : int'(v);
    endfunction

    function automatic logic same_type(input int x, input int y, input logic [2:0] t);
        if (x < 0 || y < 0 || x >= eff_dim(map_w) || y >= eff_dim(map_h)) return 1'b0;
        return tile_map[y * SIDE + x] == t;
    endfunction

    // Update the shadow map for a write, or queue the pieces a query draws.
    task automatic apply_cell_op(input logic [0:0] cmd, input logic [7:0] x,
                                 input logic [7:0] y, input logic [2:0] nt);
        logic [7:0] mask;
        logic [2:0] t;
        logic       hb, vb, db;
        int         sel;
        int         k;
        int         q;
        piece_t     p;
        if (int'(x) >= eff_dim(map_w) || int'(y) >= eff_dim(map_h)) begin
            if (cmd == CMD_QUERY) begin
                p = '{tile_type: 3'd0, part: PART_WHOLE, src_x: 6'd0, src_y: 7'd0,
                      last: 1'b1};
                pieces_due.push_back(p);
            end
            return;
        end
        if (cmd == CMD_WRITE) begin
            tile_map[{y, x}] = nt;
            return;
        end
        t = tile_map[{y, x}];
        for (k = 0; k < 8; k++) begin
            mask[k] = same_type(int'(x) + nb_dx[k], int'(y) + nb_dy[k], t);
        end
        if ((mask & ORTHO_MASK) == 8'd0) begin
            p = '{tile_type: t, part: PART_WHOLE, src_x: 6'd0, src_y: 7'd0, last: 1'b1};
            pieces_due.push_back(p);
            return;
        end
        for (q = 0; q < 4; q++) begin
            hb = mask[quad_h[q]];
            vb = mask[quad_v[q]];
            db = mask[quad_d[q]];
            if (hb && vb) sel = db ? SEL_BOTH_DIAG : SEL_BOTH;
            else if (hb)  sel = SEL_HORIZ;
            else if (vb)  sel = SEL_VERT;
            else          sel = SEL_NONE;
            p.tile_type = t;
            p.part      = quad_part[q];
            p.src_x     = 6'(sheet_x[q * 5 + sel]);
            p.src_y     = 7'(sheet_y[q * 5 + sel]);
            p.last      = (q == 3);
            pieces_due.push_back(p);
        end
    endtask

    // Input side: one transfer at a time, with a random pause after each unless no_gaps is set.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && ops_accepted != ops_launched) begin
            // The current transfer has not been taken yet.
        end else if (idle_left > 0 || ops_waiting.size() == 0) begin
            s_tvalid <= 1'b0;
            if (idle_left > 0) idle_left--;
        end else begin
            bus_op = ops_waiting.pop_front();
            s_tvalid <= 1'b1;
            s_tdata  <= {5'd0, bus_op.new_type, bus_op.y, bus_op.x};
            s_tuser  <= bus_op.cmd;
            ops_launched++;
            idle_left = no_gaps ? 0 : gap_len();
        end
    end

    // Result side back-pressure.
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            m_tready <= 1'b1;
            if (!no_gaps && $urandom_range(0, 4) == 0) stall_left = gap_len();
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.tile_type = m_tuser[2:0];
                got.part      = m_tuser[5:3];
                got.src_x     = m_tdata[5:0];
                got.src_y     = m_tdata[12:6];
                got.last      = m_tlast;
                if (pieces_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected piece: type %0d part %0d src (%0d,%0d) last %0d",
                                 got.tile_type, got.part, got.src_x, got.src_y, got.last);
                end else begin
                    want = pieces_due.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $write("piece mismatch: expected type %0d part %0d",
                                   want.tile_type, want.part);
                            $write(" src (%0d,%0d) last %0d",
                                   want.src_x, want.src_y, want.last);
                            $write(", got type %0d part %0d", got.tile_type, got.part);
                            $display(" src (%0d,%0d) last %0d",
                                     got.src_x, got.src_y, got.last);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                ops_accepted++;
                apply_cell_op(s_tuser, s_tdata[7:0], s_tdata[15:8], s_tdata[18:16]);
            end
        end
    end

    task automatic push_op(input logic [0:0] cmd, input int x, input int y, input int nt);
        cell_op_t op;
        op.cmd      = cmd;
        op.x        = 8'(x);
        op.y        = 8'(y);
        op.new_type = (cmd == CMD_QUERY) ? 3'($urandom_range(0, 7)) : 3'(nt);
        ops_waiting.push_back(op);
    endtask

    // Mostly small windows near the map edges or inside it, so that neighbors
    // often share a type; a few coordinates anywhere in the field range.
    task automatic push_random_ops(input int count);
        int w;
        int ox, oy;
        int i;
        int x, y, nt;
        w = eff_dim(map_w);
        ox = 0;
        oy = 0;
        for (i = 0; i < count; i++) begin
            if (i % 16 == 0) begin
                case ($urandom_range(0, 2))
                    0: begin
                        ox = 0;
                        oy = 0;
                    end
                    1: begin
                        ox = (w > 3) ? w - 3 : 0;
                        oy = (eff_dim(map_h) > 3) ? eff_dim(map_h) - 3 : 0;
                    end
                    default: begin
                        ox = (w > 0) ? $urandom_range(0, w - 1) : 0;
                        oy = (eff_dim(map_h) > 0) ? $urandom_range(0, eff_dim(map_h) - 1) : 0;
                    end
                endcase
            end
            x  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : ox + $urandom_range(0, 4);
            y  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : oy + $urandom_range(0, 4);
            nt = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 7) : $urandom_range(0, 1);
            push_op(($urandom_range(0, 99) < 55) ? CMD_QUERY : CMD_WRITE, x, y, nt);
        end
    endtask

    // Returns once every item is taken, every piece has arrived and the block
    // has had time to finish a trailing write.
    task automatic wait_drained();
        while (ops_waiting.size() != 0 || ops_launched != ops_accepted ||
               pieces_due.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (idx == REG_MAP_WIDTH) map_w = val;
        else                      map_h = val;
    endtask

    task automatic set_map(input int w, input int h);
        write_reg(REG_MAP_WIDTH, CFG_DATA_W'(w));
        write_reg(REG_MAP_HEIGHT, CFG_DATA_W'(h));
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(input int w, input int h, input int count, input bit steady);
        wait_drained();
        set_map(w, h);
        no_gaps = steady;
        push_random_ops(count);
    endtask

    initial begin
        for (int i = 0; i < SIDE * SIDE; i++) tile_map[i] = 3'd0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Corners and edges at the reset size, including types six and seven.
        push_op(CMD_WRITE, 0, 0, 7);
        push_op(CMD_QUERY, 0, 0, 0);
        push_op(CMD_WRITE, 249, 249, 5);
        push_op(CMD_QUERY, 249, 249, 0);
        push_op(CMD_QUERY, 250, 0, 0);
        push_op(CMD_QUERY, 0, 250, 0);
        push_op(CMD_WRITE, 255, 255, 6);
        push_op(CMD_QUERY, 255, 255, 0);
        push_op(CMD_QUERY, 100, 100, 0);
        // Both-with-diagonal, both-without-diagonal and horizontal-only pieces.
        push_op(CMD_WRITE, 20, 20, 2);
        push_op(CMD_WRITE, 21, 20, 2);
        push_op(CMD_WRITE, 20, 21, 2);
        push_op(CMD_WRITE, 19, 20, 2);
        push_op(CMD_WRITE, 19, 21, 2);
        push_op(CMD_QUERY, 20, 20, 0);
        // Vertical-only and no-match pieces.
        push_op(CMD_WRITE, 40, 40, 3);
        push_op(CMD_WRITE, 40, 39, 3);
        push_op(CMD_QUERY, 40, 40, 0);
        // Only a diagonal match still gives a whole tile.
        push_op(CMD_WRITE, 60, 60, 4);
        push_op(CMD_WRITE, 61, 61, 4);
        push_op(CMD_QUERY, 60, 60, 0);

        push_random_ops(40);
        wait_drained();
        no_gaps = 1'b1;
        push_random_ops(20);

        random_phase(256, 256, 35, 1'b0);
        random_phase(1, 1, 20, 1'b0);
        random_phase(0, 5, 15, 1'b0);
        random_phase(511, 300, 40, 1'b0);
        random_phase(4, 7, 40, 1'b1);
        random_phase(17, 3, 35, 1'b0);
        random_phase(200, 256, 35, 1'b0);
        wait_drained();

        if (mismatches == 0) begin
            $display("** autotile_quadrant_selector_top: PASSED **");
        end else begin
            $display("** autotile_quadrant_selector_top: FAILED **");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hdl
hdl/atqs_pkg.sv
hdl/autotile_quadrant_selector_top.sv
tb/autotile_quadrant_selector_top_tb.sv
